>>> hdl/xml_entity_decoder_macros.svh
// ----------------------------------------------------------------------------
// xml entity decoder assertion macros
// concurrent checks clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef XML_ENTITY_DECODER_MACROS_SVH
`define XML_ENTITY_DECODER_MACROS_SVH

// same-cycle implication
`define XED_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define XED_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg
// shared constants, types and helpers of the xml entity decoder
// ----------------------------------------------------------------------------
`default_nettype none

package xed_pkg;

    localparam int MAX_ENTITY_DEF = 16;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    localparam logic [31:0] CP_TWO_BYTE   = 32'h0000_0080;
    localparam logic [31:0] CP_THREE_BYTE = 32'h0000_0800;
    localparam logic [31:0] CP_FOUR_BYTE  = 32'h0001_0000;
    localparam logic [7:0]  UTF_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF_LEAD4     = 8'hF0;
    localparam logic [7:0]  UTF_CONT      = 8'h80;
    localparam logic [5:0]  UTF_MASK      = 6'h3F;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_SEND = 5'b00100,
        S_TAIL = 5'b01000,
        S_UTF  = 5'b10000
    } t_state;

    // value of a hex digit, zero for anything else
    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [3:0] v;
        v = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            v = b[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/xml_entity_decoder.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder
// decodes xml character entities in a byte stream into bytes and utf-8
// the first result item of an accepted item is registered and is valid in the cycle after acceptance
// plain bytes: one item per cycle while the output is not stalled; named or numeric close: 1 to 4 result bytes
// literal flush: '&', then the buffered bytes via S_READ and S_SEND, then any trailing byte via S_TAIL
// reset: synchronous active low, clears control and accumulators only
// the entity buffer memory is not cleared; only written entries are replayed
// ----------------------------------------------------------------------------
`default_nettype none

`include "xml_entity_decoder_macros.svh"

module xml_entity_decoder #(
    parameter int MAX_ENTITY = xed_pkg::MAX_ENTITY_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // last_in
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tlast,   // run_end
    output logic [0:0]      o_m_tuser    // [0] text_end
);

    localparam int CW = $clog2(MAX_ENTITY + 1);
    localparam int AW = $clog2(MAX_ENTITY);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTITY);

    logic [7:0] mem [MAX_ENTITY];

    xed_pkg::t_state r_state, n_state;
    logic            r_in_entity, n_in_entity;
    logic [CW-1:0]   r_count, n_count;
    logic [31:0]     r_dec, n_dec;
    logic [31:0]     r_hex, n_hex;
    logic [7:0]      r_head [4];
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_len, n_len;
    logic            r_tail_on, n_tail_on;
    logic [7:0]      r_tail_byte, n_tail_byte;
    logic            r_last, n_last;
    logic [23:0]     r_ubytes, n_ubytes;
    logic [1:0]      r_urem, n_urem;
    logic [7:0]      r_rd_data;
    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_run_end;
    logic            r_out_text_end;

    logic            slot_free;
    logic            s_acc;
    logic            ld;
    logic [7:0]      ld_byte;
    logic            ld_final;
    logic            ld_text;
    logic            mem_we;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   idx_inc;
    logic [31:0]     cp;
    logic [7:0]      u_first;
    logic [23:0]     u_rest;
    logic [1:0]      u_extra;
    logic            is_numeric;
    logic            is_hex;
    logic            name_lt, name_gt, name_amp, name_quot, name_apos;

    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == xed_pkg::S_IDLE) && slot_free;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign idx_inc    = r_idx + CW'(1);

    assign name_lt   = (r_count == CW'(2)) && r_head[0] == 8'h6C && r_head[1] == 8'h74;
    assign name_gt   = (r_count == CW'(2)) && r_head[0] == 8'h67 && r_head[1] == 8'h74;
    assign name_amp  = (r_count == CW'(3)) && r_head[0] == 8'h61 && r_head[1] == 8'h6D
                       && r_head[2] == 8'h70;
    assign name_quot = (r_count == CW'(4)) && r_head[0] == 8'h71 && r_head[1] == 8'h75
                       && r_head[2] == 8'h6F && r_head[3] == 8'h74;
    assign name_apos = (r_count == CW'(4)) && r_head[0] == 8'h61 && r_head[1] == 8'h70
                       && r_head[2] == 8'h6F && r_head[3] == 8'h73;
    assign is_numeric = (r_count >= CW'(1)) && r_head[0] == xed_pkg::CH_HASH;
    assign is_hex     = (r_count >= CW'(2))
                        && (r_head[1] == xed_pkg::CH_LO_X || r_head[1] == xed_pkg::CH_UP_X);
    assign cp         = is_hex ? r_hex : r_dec;

    // utf-8 encoding of the closed code point
    always_comb begin
        u_first = cp[7:0];
        u_rest  = 24'd0;
        u_extra = 2'd0;
        if (cp[31] || cp < xed_pkg::CP_TWO_BYTE) begin
            u_first = cp[7:0];
        end else if (cp < xed_pkg::CP_THREE_BYTE) begin
            u_first = xed_pkg::UTF_LEAD2 | {3'd0, cp[10:6]};
            u_rest  = {xed_pkg::UTF_CONT | {2'd0, cp[5:0]}, 16'd0};
            u_extra = 2'd1;
        end else if (cp < xed_pkg::CP_FOUR_BYTE) begin
            u_first = xed_pkg::UTF_LEAD3 | {4'd0, cp[15:12]};
            u_rest  = {xed_pkg::UTF_CONT | {2'd0, cp[11:6] & xed_pkg::UTF_MASK},
                       xed_pkg::UTF_CONT | {2'd0, cp[5:0]}, 8'd0};
            u_extra = 2'd2;
        end else begin
            u_first = xed_pkg::UTF_LEAD4 | cp[25:18];
            u_rest  = {xed_pkg::UTF_CONT | {2'd0, cp[17:12]},
                       xed_pkg::UTF_CONT | {2'd0, cp[11:6]},
                       xed_pkg::UTF_CONT | {2'd0, cp[5:0]}};
            u_extra = 2'd3;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_in_entity = r_in_entity;
        n_count     = r_count;
        n_dec       = r_dec;
        n_hex       = r_hex;
        n_idx       = r_idx;
        n_len       = r_len;
        n_tail_on   = r_tail_on;
        n_tail_byte = r_tail_byte;
        n_last      = r_last;
        n_ubytes    = r_ubytes;
        n_urem      = r_urem;
        ld          = 1'b0;
        ld_byte     = i_s_tdata;
        ld_final    = 1'b0;
        ld_text     = 1'b0;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_idx[AW-1:0];
        unique case (r_state)
            xed_pkg::S_IDLE: begin
                if (s_acc) begin
                    n_last = i_s_tlast;
                    n_idx  = '0;
                    if (!r_in_entity) begin
                        if (i_s_tdata == xed_pkg::CH_AMP) begin
                            n_in_entity = !i_s_tlast;
                            n_count     = '0;
                            n_dec       = '0;
                            n_hex       = '0;
                            if (i_s_tlast) begin
                                ld       = 1'b1;
                                ld_byte  = xed_pkg::CH_AMP;
                                ld_final = 1'b1;
                                ld_text  = 1'b1;
                            end
                        end else begin
                            ld       = 1'b1;
                            ld_final = 1'b1;
                            ld_text  = i_s_tlast;
                        end
                    end else if (i_s_tdata == xed_pkg::CH_SEMI) begin
                        n_in_entity = 1'b0;
                        n_count     = '0;
                        ld          = 1'b1;
                        priority if (name_lt) begin
                            ld_byte  = xed_pkg::CH_LT;
                            ld_final = 1'b1;
                        end else if (name_gt) begin
                            ld_byte  = xed_pkg::CH_GT;
                            ld_final = 1'b1;
                        end else if (name_amp) begin
                            ld_byte  = xed_pkg::CH_AMP;
                            ld_final = 1'b1;
                        end else if (name_quot) begin
                            ld_byte  = xed_pkg::CH_QUOT;
                            ld_final = 1'b1;
                        end else if (name_apos) begin
                            ld_byte  = xed_pkg::CH_APOS;
                            ld_final = 1'b1;
                        end else if (is_numeric) begin
                            ld_byte  = u_first;
                            ld_final = (u_extra == 2'd0);
                            n_ubytes = u_rest;
                            n_urem   = u_extra;
                            if (u_extra != 2'd0) begin
                                n_state = xed_pkg::S_UTF;
                            end
                        end else begin
                            ld_byte     = xed_pkg::CH_AMP;
                            n_len       = r_count;
                            n_tail_on   = 1'b1;
                            n_tail_byte = xed_pkg::CH_SEMI;
                            n_state     = (r_count == '0) ? xed_pkg::S_TAIL : xed_pkg::S_READ;
                        end
                        ld_text = i_s_tlast && ld_final;
                    end else if (r_count < MAX_CNT) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        if (r_count >= CW'(1)) begin
                            n_dec = (r_dec << 3) + (r_dec << 1) + {24'd0, i_s_tdata}
                                    - {24'd0, xed_pkg::CH_ZERO};
                        end
                        if (r_count >= CW'(2)) begin
                            n_hex = {r_hex[27:0], xed_pkg::hex_value(i_s_tdata)};
                        end
                        if (i_s_tlast) begin
                            ld          = 1'b1;
                            ld_byte     = xed_pkg::CH_AMP;
                            n_len       = r_count + CW'(1);
                            n_tail_on   = 1'b0;
                            n_in_entity = 1'b0;
                            n_count     = '0;
                            n_state     = xed_pkg::S_READ;
                        end
                    end else begin
                        // buffer full: literal flush, item as text unless a non-last '&' opens an entity
                        ld          = 1'b1;
                        ld_byte     = xed_pkg::CH_AMP;
                        n_len       = MAX_CNT;
                        n_state     = xed_pkg::S_READ;
                        n_in_entity = 1'b0;
                        n_count     = '0;
                        n_tail_on   = 1'b1;
                        n_tail_byte = i_s_tdata;
                        if (i_s_tdata == xed_pkg::CH_AMP) begin
                            n_in_entity = !i_s_tlast;
                            n_dec       = '0;
                            n_hex       = '0;
                            n_tail_on   = i_s_tlast;
                        end
                    end
                end
            end
            xed_pkg::S_READ: begin
                rd_en   = 1'b1;
                n_state = xed_pkg::S_SEND;
            end
            xed_pkg::S_SEND: begin
                if (slot_free) begin
                    ld       = 1'b1;
                    ld_byte  = r_rd_data;
                    ld_final = (idx_inc == r_len) && !r_tail_on;
                    ld_text  = r_last && ld_final;
                    n_idx    = idx_inc;
                    if (idx_inc < r_len) begin
                        rd_en   = 1'b1;
                        rd_addr = idx_inc[AW-1:0];
                    end else if (r_tail_on) begin
                        n_state = xed_pkg::S_TAIL;
                    end else begin
                        n_state = xed_pkg::S_IDLE;
                    end
                end
            end
            xed_pkg::S_TAIL: begin
                if (slot_free) begin
                    ld       = 1'b1;
                    ld_byte  = r_tail_byte;
                    ld_final = 1'b1;
                    ld_text  = r_last;
                    n_state  = xed_pkg::S_IDLE;
                end
            end
            xed_pkg::S_UTF: begin
                if (slot_free) begin
                    ld       = 1'b1;
                    ld_byte  = r_ubytes[23:16];
                    ld_final = (r_urem == 2'd1);
                    ld_text  = r_last && ld_final;
                    n_ubytes = {r_ubytes[15:0], 8'd0};
                    n_urem   = r_urem - 2'd1;
                    if (r_urem == 2'd1) begin
                        n_state = xed_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = xed_pkg::S_IDLE;
            end
        endcase
    end

    // entity buffer; writes only while idle, reads only while flushing
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= i_s_tdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we && r_count < CW'(4)) begin
            r_head[r_count[1:0]] <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xed_pkg::S_IDLE;
            r_in_entity <= 1'b0;
            r_count     <= '0;
            r_dec       <= '0;
            r_hex       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_entity <= n_in_entity;
            r_count     <= n_count;
            r_dec       <= n_dec;
            r_hex       <= n_hex;
            if (ld) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_len       <= n_len;
        r_tail_on   <= n_tail_on;
        r_tail_byte <= n_tail_byte;
        r_last      <= n_last;
        r_ubytes    <= n_ubytes;
        r_urem      <= n_urem;
        if (ld) begin
            r_out_byte     <= ld_byte;
            r_out_run_end  <= ld_final;
            r_out_text_end <= ld_text;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_byte;
    assign o_m_tlast    = r_out_run_end;
    assign o_m_tuser[0] = r_out_text_end;

    `XED_ASSERT_IMP(a_text_end_is_run_end, o_m_tvalid && o_m_tuser[0], o_m_tlast,
        "text end without run end")
    `XED_ASSERT_NXT(a_last_closes_entity, s_acc && i_s_tlast, !r_in_entity,
        "entity still open after last item")
    `XED_ASSERT_IMP(a_count_bounded, 1'b1, r_count <= MAX_CNT,
        "entity count beyond buffer depth")
    `XED_ASSERT_IMP(a_send_index_in_range, r_state == xed_pkg::S_SEND, r_idx < r_len,
        "flush index past buffered length")
    `XED_ASSERT_IMP(a_no_write_while_busy, r_state != xed_pkg::S_IDLE, !mem_we,
        "buffer written during flush")

endmodule

`default_nettype wire
